@@ src/pbi_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pbi_pkg - shared definitions for point_to_beam_index
// Widths, register indices, word structs and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package pbi_pkg;

    localparam int BEAM_COUNT   = 1024;
    localparam int CORDIC_STEPS = 18;

    localparam int PT_W      = 32;               // point coordinates, Q15.16
    localparam int CFG_W     = 32;               // config write data
    localparam int REG_IDX_W = 3;
    localparam int POSE_W    = 18;               // Q1.16
    localparam int SHIFT_W   = 32;               // Q15.16
    localparam int ANG0_W    = 19;               // Q2.16
    localparam int BPR_W     = 32;               // Q16.16 unsigned
    localparam int FRAC      = 16;
    localparam int BEAM_W    = 10;

    localparam int PROD_W = POSE_W + PT_W;            // one pose product
    localparam int T_W    = PROD_W + 1 - FRAC + 1;    // sensor-frame coordinate
    localparam int C_W    = T_W + 3;                  // CORDIC x/y, gain headroom
    localparam int Z_W    = 20;                       // Q3.16 angle accumulator
    localparam int D_W    = Z_W + 1;                  // angle minus first beam
    localparam int S_W    = D_W + BPR_W + 1;          // scaled offset, Q.32
    localparam int IDX_W  = S_W - 32;
    localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    localparam logic signed [Z_W-1:0] ANG_PI = Z_W'(205887);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_POSE_XX   = 3'd0,
        REG_POSE_XY   = 3'd1,
        REG_POSE_YX   = 3'd2,
        REG_POSE_YY   = 3'd3,
        REG_SHIFT_X   = 3'd4,
        REG_SHIFT_Y   = 3'd5,
        REG_ANG0      = 3'd6,
        REG_BEAMS_RAD = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [POSE_W-1:0]  xx;
        logic signed [POSE_W-1:0]  xy;
        logic signed [POSE_W-1:0]  yx;
        logic signed [POSE_W-1:0]  yy;
        logic signed [SHIFT_W-1:0] sx;
        logic signed [SHIFT_W-1:0] sy;
    } t_pose;

    // word handed from cell to cell
    typedef struct packed {
        logic                   hold;   // bearing already settled (zero ordinate)
        logic signed [C_W-1:0]  x;
        logic signed [C_W-1:0]  y;
        logic signed [Z_W-1:0]  z;
    } t_cord;

    // atan(2^-i) in Q3.16, rounded
    function automatic logic [15:0] atan_lut(input logic [4:0] idx);
        logic [15:0] v;
        case (idx)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30386;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ src/pbi_xform.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pbi_xform - inverse pose transform and quadrant fold
// Three stages: products, sums plus translation, fold into the right half-plane.
// ----------------------------------------------------------------------------
module pbi_xform
    import pbi_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_pose                  i_pose,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic signed [PT_W-1:0] i_point_x,
    input  wire logic signed [PT_W-1:0] i_point_y,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output t_cord                       o_data
);

    logic                     r_v1, r_v2, r_v3;
    logic                     en1, en2, en3;
    logic signed [PROD_W-1:0] r_pxx, r_pxy, r_pyx, r_pyy;
    logic signed [T_W-1:0]    r_tx, r_ty;
    logic signed [T_W-1:0]    n_tx, n_ty;
    logic signed [PROD_W:0]   sum_x, sum_y;
    t_cord                    r_cd, n_cd;

    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v3;
    assign o_data  = r_cd;

    always_comb begin
        sum_x = {r_pxx[PROD_W-1], r_pxx} + {r_pxy[PROD_W-1], r_pxy};
        sum_y = {r_pyx[PROD_W-1], r_pyx} + {r_pyy[PROD_W-1], r_pyy};
        n_tx  = T_W'(sum_x >>> FRAC) + T_W'(i_pose.sx);
        n_ty  = T_W'(sum_y >>> FRAC) + T_W'(i_pose.sy);
    end

    // fold the left half-plane over by +-pi; zero ordinate settles at once
    always_comb begin
        n_cd.hold = 1'b0;
        n_cd.x    = C_W'(r_tx);
        n_cd.y    = C_W'(r_ty);
        n_cd.z    = '0;
        if (r_ty == '0) begin
            n_cd.hold = 1'b1;
            n_cd.z    = r_tx[T_W-1] ? ANG_PI : '0;
        end else if (r_tx[T_W-1]) begin
            n_cd.x = -C_W'(r_tx);
            n_cd.y = -C_W'(r_ty);
            n_cd.z = r_ty[T_W-1] ? -ANG_PI : ANG_PI;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
        if (en1) begin
            r_pxx <= i_pose.xx * i_point_x;
            r_pxy <= i_pose.xy * i_point_y;
            r_pyx <= i_pose.yx * i_point_x;
            r_pyy <= i_pose.yy * i_point_y;
        end
        if (en2) begin
            r_tx <= n_tx;
            r_ty <= n_ty;
        end
        if (en3) r_cd <= n_cd;
    end

endmodule
`default_nettype wire

@@ src/pbi_cordic_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pbi_cordic_cell - one vectoring micro-rotation
// Rotates toward the x axis by atan(2^-step) and registers the word.
// ----------------------------------------------------------------------------
module pbi_cordic_cell
    import pbi_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [STEP_W-1:0] i_step,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire t_cord             i_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output t_cord                  o_data
);

    logic                  r_v;
    logic                  en;
    t_cord                 r_cd, n_cd;
    logic signed [C_W-1:0] dx, dy;
    logic signed [Z_W-1:0] ang;

    assign en      = !r_v || i_ready;
    assign o_ready = en;
    assign o_valid = r_v;
    assign o_data  = r_cd;

    always_comb begin
        dx   = i_data.y >>> i_step;
        dy   = i_data.x >>> i_step;
        ang  = Z_W'(atan_lut(5'(i_step)));
        n_cd = i_data;
        if (!i_data.hold) begin
            if (i_data.y > 0) begin
                n_cd.x = i_data.x + dx;
                n_cd.y = i_data.y - dy;
                n_cd.z = i_data.z + ang;
            end else begin
                n_cd.x = i_data.x - dx;
                n_cd.y = i_data.y + dy;
                n_cd.z = i_data.z - ang;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
        if (en) r_cd <= n_cd;
    end

    // a settled bearing crosses the cell untouched
    a_hold_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_data.hold) |=>
            (o_data.hold && o_data.z == $past(i_data.z)))
        else $error("settled bearing altered in cell");

endmodule
`default_nettype wire

@@ src/pbi_quant.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pbi_quant - angle to beam index
// Subtracts the first beam angle, scales, rounds half up and range checks.
// ----------------------------------------------------------------------------
module pbi_quant
    import pbi_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic signed [ANG0_W-1:0] i_ang0,
    input  wire logic [BPR_W-1:0]         i_bpr,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire t_cord                    i_data,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic [BEAM_W-1:0]             o_beam_index,
    output logic                          o_out_of_range
);

    localparam logic signed [S_W-1:0] S_HALF = S_W'(1) <<< 31;
    localparam logic signed [S_W-1:0] S_TOP  = S_W'(BEAM_COUNT) <<< 32;
    localparam logic [IDX_W-1:0]      IDX_TOP = IDX_W'(BEAM_COUNT);

    logic                  r_v1, r_out_valid;
    logic                  en1, en2;
    logic signed [D_W-1:0] d;
    logic signed [S_W-1:0] r_s, n_s, s_rnd;
    logic [IDX_W-1:0]      idx;
    logic                  oor;
    logic [BEAM_W-1:0]     r_beam, n_beam;
    logic                  r_oor;

    assign en2            = !r_out_valid || i_ready;
    assign en1            = !r_v1 || en2;
    assign o_ready        = en1;
    assign o_valid        = r_out_valid;
    assign o_beam_index   = r_beam;
    assign o_out_of_range = r_oor;

    always_comb begin
        d   = D_W'(i_data.z) - D_W'(i_ang0);
        n_s = S_W'(d) * S_W'($signed({1'b0, i_bpr}));
    end

    always_comb begin
        s_rnd  = r_s + S_HALF;
        idx    = IDX_W'(s_rnd >>> 32);
        oor    = (r_s <= -S_HALF) || (r_s >= S_TOP) || (idx >= IDX_TOP);
        n_beam = oor ? '0 : idx[BEAM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en1) r_v1        <= i_valid;
            if (en2) r_out_valid <= r_v1;
        end
        if (en1) r_s <= n_s;
        if (en2) begin
            r_beam <= n_beam;
            r_oor  <= oor;
        end
    end

endmodule
`default_nettype wire

@@ src/point_to_beam_index.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// point_to_beam_index - map a world point to the nearest sensor beam
// Inverse pose transform, CORDIC bearing, scaling and round to a beam index.
// ----------------------------------------------------------------------------
// Usage
//   Input channel  : i_in_valid / o_in_ready carry one point word
//                    (i_point_x, i_point_y, Q15.16 signed).
//   Output channel : o_out_valid / i_out_ready carry one result word per point
//                    (o_beam_index, o_out_of_range). Out of range gives index 0.
//   Config channel : i_cfg_valid / o_cfg_ready with i_cfg_index, i_cfg_data.
//                    Always ready; write only while no point is in flight.
// Timing
//   Fully pipelined: one point per cycle while the receiver takes results.
//   From the input handshake to o_out_valid a point passes the three
//   transform stages, one cell per micro-rotation, the scaling multiply
//   and the output register. CORDIC_STEPS sets the cell chain length.
// Reset
//   i_rst_n is synchronous, active low. All stages empty; registers return
//   to the identity pose, first beam angle 0 and one beam per radian.
// Stall
//   Each stage moves on when the stage after it is empty or moving, so a
//   stalled receiver only backs up the pipeline once every stage is full;
//   until then new points are still taken.
// ----------------------------------------------------------------------------
module point_to_beam_index
    import pbi_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // config
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [REG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    // points in
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [PT_W-1:0]      i_point_x,
    input  wire logic [PT_W-1:0]      i_point_y,
    // beams out
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [BEAM_W-1:0]         o_beam_index,
    output logic                      o_out_of_range
);

    // configuration registers
    t_pose                    r_pose;
    logic signed [ANG0_W-1:0] r_ang0;
    logic [BPR_W-1:0]         r_bpr;

    // cell chain words; slot 0 is fed by the transform, the last by the cells
    logic  chain_v [CORDIC_STEPS+1];
    logic  chain_r [CORDIC_STEPS+1];
    t_cord chain_d [CORDIC_STEPS+1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pose.xx <= POSE_W'(65536);
            r_pose.xy <= '0;
            r_pose.yx <= '0;
            r_pose.yy <= POSE_W'(65536);
            r_pose.sx <= '0;
            r_pose.sy <= '0;
            r_ang0    <= '0;
            r_bpr     <= BPR_W'(65536);
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_POSE_XX:   r_pose.xx <= i_cfg_data[POSE_W-1:0];
                REG_POSE_XY:   r_pose.xy <= i_cfg_data[POSE_W-1:0];
                REG_POSE_YX:   r_pose.yx <= i_cfg_data[POSE_W-1:0];
                REG_POSE_YY:   r_pose.yy <= i_cfg_data[POSE_W-1:0];
                REG_SHIFT_X:   r_pose.sx <= i_cfg_data[SHIFT_W-1:0];
                REG_SHIFT_Y:   r_pose.sy <= i_cfg_data[SHIFT_W-1:0];
                REG_ANG0:      r_ang0    <= i_cfg_data[ANG0_W-1:0];
                REG_BEAMS_RAD: r_bpr     <= i_cfg_data[BPR_W-1:0];
            endcase
        end
    end

    // pose transform and half-plane fold
    pbi_xform u_xform (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pose    (r_pose),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_point_x ($signed(i_point_x)),
        .i_point_y ($signed(i_point_y)),
        .o_valid   (chain_v[0]),
        .i_ready   (chain_r[0]),
        .o_data    (chain_d[0])
    );

    // one micro-rotation per cell
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
        pbi_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (STEP_W'(k)),
            .i_valid (chain_v[k]),
            .o_ready (chain_r[k]),
            .i_data  (chain_d[k]),
            .o_valid (chain_v[k+1]),
            .i_ready (chain_r[k+1]),
            .o_data  (chain_d[k+1])
        );
    end

    // scale, round and range check
    pbi_quant u_quant (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ang0         (r_ang0),
        .i_bpr          (r_bpr),
        .i_valid        (chain_v[CORDIC_STEPS]),
        .o_ready        (chain_r[CORDIC_STEPS]),
        .i_data         (chain_d[CORDIC_STEPS]),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_beam_index   (o_beam_index),
        .o_out_of_range (o_out_of_range)
    );

    // flagged results carry a zero index
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_of_range) |-> (o_beam_index == '0))
        else $error("out of range word with non-zero index");

    // an index that is given lies inside the fan
    a_idx_in_fan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_of_range) |-> (32'(o_beam_index) < BEAM_COUNT))
        else $error("beam index beyond beam count");

    // back-pressure reaches the input only through a full, stalled output
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled while output not blocked");

endmodule
`default_nettype wire
